@@ design/stc_pkg.sv @@
// Shared types and constants for the segment tree range minimum unit.
// Used by the channel interfaces and by every module of the design but stc_queue.
package stc_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic REG_ELEMENT_COUNT = 1'b0;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_kind_t;

endpackage

@@ design/stc_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on stc_pkg for the field widths.
interface stc_in_if;
  import stc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [INDEX_W-1:0]        elem_index;
  logic signed [VALUE_W-1:0] elem_value;
  logic [INDEX_W-1:0]        range_start;
  logic [INDEX_W-1:0]        range_end;

  modport source (
    output valid, func, elem_index, elem_value, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, func, elem_index, elem_value, range_start, range_end,
    output ready
  );
endinterface

interface stc_out_if;
  import stc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] min_value;
  logic                      range_empty;

  modport source (
    output valid, min_value, range_empty,
    input  ready
  );
  modport sink (
    input  valid, min_value, range_empty,
    output ready
  );
endinterface

@@ design/stc_front.sv @@
// Front end: configuration register, input transfers and item classification.
// Depends on stc_pkg and stc_in_if; feeds commands to the queue.
module stc_front #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  stc_in_if.sink                         items,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::ADDR_W-1:0]     paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [2*$clog2(2*LEAF_COUNT)+stc_pkg::VALUE_W+2:0] q_data
);
  import stc_pkg::*;

  localparam int NW = $clog2(2 * LEAF_COUNT);
  localparam int HW = NW + 1;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [NW-1:0]             lo;
    logic [HW-1:0]             hi;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  logic [COUNT_W-1:0] element_count;
  logic               cfg_sel;
  logic               load_ok;
  logic [NW-1:0]      ld_leaf;
  logic [NW-1:0]      s_leaf;
  logic [NW-1:0]      e_leaf;
  cmd_t               cmd;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ADDR_W-1:2] == REG_ELEMENT_COUNT);
  assign prdata  = cfg_sel ? CFG_DATA_W'(element_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      element_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    load_ok = ({1'b0, items.elem_index} < element_count) &&
              (32'(items.elem_index) < LEAF_COUNT);
    ld_leaf = NW'(items.elem_index);
    s_leaf  = (32'(items.range_start) > LEAF_COUNT - 1) ? NW'(LEAF_COUNT - 1)
                                                         : NW'(items.range_start);
    e_leaf  = (32'(items.range_end) > LEAF_COUNT - 1) ? NW'(LEAF_COUNT - 1)
                                                       : NW'(items.range_end);
    cmd.value = items.elem_value;
    cmd.hi    = HW'(LEAF_COUNT) + HW'(e_leaf) + HW'(1);
    if (items.func == FUNC_LOAD) begin
      cmd.kind = CMD_LOAD;
      cmd.lo   = NW'(LEAF_COUNT) + ld_leaf;
    end else begin
      cmd.kind = (s_leaf > e_leaf) ? CMD_EMPTY : CMD_QUERY;
      cmd.lo   = NW'(LEAF_COUNT) + s_leaf;
    end
  end

  assign items.ready = !q_full && !clearing;
  assign q_push      = items.valid && items.ready &&
                       ((items.func == FUNC_QUERY) || load_ok);
  assign q_data      = cmd;

endmodule

@@ design/stc_queue.sv @@
// Two-entry command queue between the front end and the tree engine.
// Self-contained; the entry width comes from the top level.
module stc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/stc_back.sv @@
// Tree engine: node memory, clearing pass, leaf updates and range walks.
// Depends on stc_pkg and stc_out_if; takes commands from the queue.
module stc_back #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  logic [2*$clog2(2*LEAF_COUNT)+stc_pkg::VALUE_W+2:0] q_data,
  output logic clearing,
  stc_out_if.source results
);
  import stc_pkg::*;

  localparam int NW = $clog2(2 * LEAF_COUNT);
  localparam int HW = NW + 1;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [NW-1:0]             lo;
    logic [HW-1:0]             hi;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_LOAD_RD,
    ST_Q_CHECK,
    ST_Q_LO,
    ST_Q_HI,
    ST_Q_OUT
  } state_t;

  function automatic logic signed [VALUE_W-1:0] smin(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  logic signed [VALUE_W-1:0] mem [2*LEAF_COUNT];
  logic signed [VALUE_W-1:0] rdata;
  logic [NW-1:0]             rd_addr;
  logic [NW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      wr_en;

  state_t                    state;
  logic [NW-1:0]             clr_addr;
  logic [HW-1:0]             lo;
  logic [HW-1:0]             hi;
  logic [HW-1:0]             hi_dec;
  logic [HW-1:0]             lo_inc;
  logic signed [VALUE_W-1:0] best;
  logic                      empty_flag;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_min;
  logic                      out_empty;
  cmd_t                      cmd;

  assign cmd      = q_data;
  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign hi_dec   = hi - HW'(1);
  assign lo_inc   = lo + HW'(1);

  assign results.valid       = out_valid;
  assign results.min_value   = out_min;
  assign results.range_empty = out_empty;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lo[NW-1:0];
    wr_data = best;
    rd_addr = lo[NW-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = INT_MAX;
      end
      ST_LOAD_WR: begin
        wr_en   = 1'b1;
        rd_addr = lo[NW-1:0] ^ NW'(1);
      end
      ST_Q_CHECK: begin
        rd_addr = lo[0] ? lo[NW-1:0] : hi_dec[NW-1:0];
      end
      ST_Q_LO: begin
        rd_addr = hi_dec[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (results.ready && (state != ST_Q_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            lo         <= HW'(cmd.lo);
            hi         <= cmd.hi;
            empty_flag <= (cmd.kind == CMD_EMPTY);
            best       <= (cmd.kind == CMD_LOAD) ? cmd.value : INT_MAX;
            unique case (cmd.kind)
              CMD_LOAD:  state <= ST_LOAD_WR;
              CMD_QUERY: state <= ST_Q_CHECK;
              default:   state <= ST_Q_OUT;
            endcase
          end
        end
        ST_LOAD_WR: begin
          state <= (lo == HW'(1)) ? ST_IDLE : ST_LOAD_RD;
        end
        ST_LOAD_RD: begin
          best  <= smin(best, rdata);
          lo    <= lo >> 1;
          state <= ST_LOAD_WR;
        end
        ST_Q_CHECK: begin
          if (lo >= hi) begin
            state <= ST_Q_OUT;
          end else if (lo[0]) begin
            state <= ST_Q_LO;
          end else if (hi[0]) begin
            state <= ST_Q_HI;
          end else begin
            lo <= lo >> 1;
            hi <= hi >> 1;
          end
        end
        ST_Q_LO: begin
          best <= smin(best, rdata);
          if (hi[0]) begin
            lo    <= lo_inc;
            state <= ST_Q_HI;
          end else begin
            lo    <= lo_inc >> 1;
            hi    <= hi >> 1;
            state <= ST_Q_CHECK;
          end
        end
        ST_Q_HI: begin
          best  <= smin(best, rdata);
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= ST_Q_CHECK;
        end
        ST_Q_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_min   <= best;
            out_empty <= empty_flag;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/segment_tree_range_min_unit.sv @@
// Top level of the segment tree range minimum unit.
// Depends on stc_pkg, stc_if, stc_front, stc_queue and stc_back.
//
//   Channel  Direction  Carries
//   items    in         func, elem_index, elem_value, range_start, range_end
//   results  out        min_value, range_empty (one per query, none per load)
//   APB      in/out     element_count at byte address 0
//
// After reset a clearing pass writes every node, with items held off.
// A load does one node memory read and one write per level.
// A query reads its nodes one at a time through the single node memory read port.
// Items wait in a two-entry queue; a finished result sits in an output register.
module segment_tree_range_min_unit #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  stc_in_if.sink                         items,
  stc_out_if.source                      results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::ADDR_W-1:0]     paddr,
  input  logic [stc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import stc_pkg::*;

  localparam int NW = $clog2(2 * LEAF_COUNT);
  localparam int CMD_W = 2 * NW + VALUE_W + 3;

  logic             clearing;
  logic             q_full;
  logic             q_push;
  logic [CMD_W-1:0] q_push_data;
  logic             q_pop;
  logic [CMD_W-1:0] q_pop_data;
  logic             q_empty;

  stc_front #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clearing(clearing),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  stc_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  stc_back #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_pop_data),
    .clearing(clearing),
    .results (results)
  );

endmodule

@@ dv/stc_range_min_checker.sv @@
// Checker for the segment tree range minimum unit. It watches item, result and
// register transfers, keeps its own copy of the leaves and compares every result.
// Depends on stc_pkg.
module stc_range_min_checker
  import stc_pkg::*;
#(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic                      item_func,
  input  logic [INDEX_W-1:0]        item_index,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [INDEX_W-1:0]        item_start,
  input  logic [INDEX_W-1:0]        item_end,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic signed [VALUE_W-1:0] result_min,
  input  logic                      result_empty,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output int                        fail_count,
  output int                        pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] ADDR_ELEMENT_COUNT = ADDR_W'(4 * REG_ELEMENT_COUNT);

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic                      range_empty;
  } range_min_t;

  logic signed [VALUE_W-1:0] leaf_value [LEAF_COUNT];
  logic [COUNT_W-1:0]        element_count;
  range_min_t                expected_minima [$];

  function automatic range_min_t range_minimum(input logic [INDEX_W-1:0] first,
                                               input logic [INDEX_W-1:0] last);
    range_min_t                outcome;
    logic signed [VALUE_W-1:0] lowest;
    lowest = INT_MAX;
    outcome.range_empty = (first > last);
    if (!outcome.range_empty) begin
      for (int k = int'(first); k <= int'(last); k++) begin
        if (leaf_value[k] < lowest) begin
          lowest = leaf_value[k];
        end
      end
    end
    outcome.min_value = lowest;
    return outcome;
  endfunction

  always @(posedge clk) begin : watch
    range_min_t want;
    if (rst) begin
      foreach (leaf_value[k]) begin
        leaf_value[k] = INT_MAX;
      end
      element_count = COUNT_RESET;
      expected_minima.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_ELEMENT_COUNT) begin
        element_count = pwdata[COUNT_W-1:0];
      end
      if (result_valid && result_ready) begin
        if (expected_minima.size() == 0) begin
          $error("result with no query waiting: min_value %0d, range_empty %0b",
                 result_min, result_empty);
          fail_count++;
        end else begin
          want = expected_minima.pop_front();
          if (result_min !== want.min_value) begin
            $error("min_value: expected %0d, actual %0d", $signed(want.min_value),
                   result_min);
            fail_count++;
          end
          if (result_empty !== want.range_empty) begin
            $error("range_empty: expected %0b, actual %0b", want.range_empty,
                   result_empty);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item_func == FUNC_QUERY) begin
          expected_minima.push_back(range_minimum(item_start, item_end));
        end else if ({1'b0, item_index} < element_count) begin
          leaf_value[item_index] = item_value;
        end
      end
    end
    pending_results = expected_minima.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the testbench for the segment tree range minimum unit: clock, reset,
// directed and random item stimulus, result back-pressure and the verdict.
// Depends on stc_pkg, stc_if, the unit itself and stc_range_min_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;

  localparam int LEAF_COUNT    = 1024;
  localparam int IDLE_PCT      = 14;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 145;
  localparam int HOLD_CYCLES   = 400;
  localparam int FIRST_HOLD    = 60;
  localparam int SECOND_HOLD   = 250;
  localparam logic [ADDR_W-1:0] ADDR_ELEMENT_COUNT = ADDR_W'(4 * REG_ELEMENT_COUNT);
  localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [INDEX_W-1:0] LAST_LEAF = INDEX_W'(LEAF_COUNT - 1);

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending_results;
  int                    items_sent;
  int                    idle_cycles = 0;
  logic [COUNT_W-1:0]    element_count_now;

  stc_in_if  items_ch ();
  stc_out_if results_ch ();

  segment_tree_range_min_unit #(.LEAF_COUNT(LEAF_COUNT)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stc_range_min_checker #(.LEAF_COUNT(LEAF_COUNT)) range_min_check (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (items_ch.valid),
    .item_ready      (items_ch.ready),
    .item_func       (items_ch.func),
    .item_index      (items_ch.elem_index),
    .item_value      (items_ch.elem_value),
    .item_start      (items_ch.range_start),
    .item_end        (items_ch.range_end),
    .result_valid    (results_ch.valid),
    .result_ready    (results_ch.ready),
    .result_min      (results_ch.min_value),
    .result_empty    (results_ch.range_empty),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** segment_tree_range_min_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver holds off twice for a long stretch so that the unit fills up.
  initial begin : result_sink
    int taken;
    int next_hold;
    taken = 0;
    next_hold = FIRST_HOLD;
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (results_ch.valid && results_ch.ready) begin
        taken++;
      end
      @(negedge clk);
      if (taken >= next_hold) begin
        next_hold = (next_hold == FIRST_HOLD) ? SECOND_HOLD : 32'h7FFF_FFFF;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      results_ch.ready <= (taken >= 150 && taken < 230) ||
                          ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return VALUE_W'($urandom_range(16) - 8);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic offer_item(input logic func, input logic [INDEX_W-1:0] index,
                            input logic signed [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] first,
                            input logic [INDEX_W-1:0] last);
    while (!(items_sent >= 300 && items_sent < 420) &&
           $urandom_range(99) < IDLE_PCT) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid       <= 1'b1;
    items_ch.func        <= func;
    items_ch.elem_index  <= index;
    items_ch.elem_value  <= value;
    items_ch.range_start <= first;
    items_ch.range_end   <= last;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_leaf(input logic [INDEX_W-1:0] index,
                           input logic signed [VALUE_W-1:0] value);
    offer_item(FUNC_LOAD, index, value, INDEX_W'($urandom), INDEX_W'($urandom));
  endtask

  task automatic query_range(input logic [INDEX_W-1:0] first,
                             input logic [INDEX_W-1:0] last);
    offer_item(FUNC_QUERY, INDEX_W'($urandom), VALUE_W'($urandom), first, last);
  endtask

  // Loads give no result, so a fixed settle time follows the last result.
  task automatic wait_for_results();
    items_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_element_count(input logic [COUNT_W-1:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEMENT_COUNT;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    element_count_now = value;
  endtask

  // Most loads land below the element count and most queries cover live leaves.
  task automatic random_item();
    int span;
    int first;
    int last;
    span = (element_count_now == '0 || int'(element_count_now) > LEAF_COUNT) ?
           LEAF_COUNT : int'(element_count_now);
    if ($urandom_range(99) < 45) begin
      if ($urandom_range(9) == 0) begin
        first = $urandom_range(LEAF_COUNT - 1);
      end else begin
        first = $urandom_range(span - 1);
      end
      load_leaf(INDEX_W'(first), pick_value());
    end else begin
      first = $urandom_range(span - 1);
      case ($urandom_range(9))
        0: begin
          first = $urandom_range(LEAF_COUNT - 1, 1);
          last = $urandom_range(first - 1);
        end
        1, 2, 3: last = first + $urandom_range(7);
        4: last = first;
        5: last = LEAF_COUNT - 1;
        default: last = $urandom_range(LEAF_COUNT - 1, first);
      endcase
      if (last > LEAF_COUNT - 1) begin
        last = LEAF_COUNT - 1;
      end
      query_range(INDEX_W'(first), INDEX_W'(last));
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] phase_counts [5];
    rst                  = 1'b1;
    items_ch.valid       = 1'b0;
    items_ch.func        = FUNC_LOAD;
    items_ch.elem_index  = '0;
    items_ch.elem_value  = '0;
    items_ch.range_start = '0;
    items_ch.range_end   = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    items_sent           = 0;
    element_count_now    = COUNT_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    query_range(10'd0, LAST_LEAF);
    load_leaf(10'd0, INT_MIN);
    load_leaf(LAST_LEAF, INT_MAX);
    load_leaf(10'd512, 32'sd0);
    load_leaf(10'd1, -32'sd1);
    load_leaf(LAST_LEAF - 10'd1, 32'sd1);
    load_leaf(10'h155, 32'sh5555_5555);
    load_leaf(10'h2AA, 32'shAAAA_AAAA);
    query_range(10'd0, 10'd0);
    query_range(LAST_LEAF, LAST_LEAF);
    query_range(10'd0, LAST_LEAF);
    query_range(10'd1, LAST_LEAF - 10'd1);
    query_range(10'd5, 10'd4);
    query_range(LAST_LEAF, 10'd0);
    query_range(10'd513, 10'd681);
    query_range(10'd512, 10'd512);

    // With a zero count every load is dropped.
    write_element_count('0);
    load_leaf(10'd3, -32'sd5);
    query_range(10'd2, 10'd4);

    // Lowering the count keeps leaves that were written earlier.
    write_element_count(11'd1);
    load_leaf(10'd0, 32'sd7);
    load_leaf(10'd1, -32'sd9);
    query_range(10'd0, 10'd1);
    query_range(10'd0, LAST_LEAF);
    load_leaf(LAST_LEAF, -32'sd2);
    query_range(10'd1000, LAST_LEAF);

    phase_counts = '{COUNT_RESET, 11'd2047, COUNT_W'($urandom_range(1023, 2)), 11'd1,
                     COUNT_RESET};
    for (int p = 0; p < 5; p++) begin
      write_element_count(phase_counts[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == PHASE_ITEMS / 2) begin
          wait_for_results();
        end
        random_item();
      end
    end

    wait_for_results();
    if (fail_count == 0 && pending_results == 0) begin
      $display("** segment_tree_range_min_unit: PASSED **");
    end else begin
      $display("** segment_tree_range_min_unit: FAILED **");
    end
    $finish;
  end

endmodule
